[sv/wav_pcm_to_float_converter_macros.svh]
// ----------------------------------------------------------------------------
// WAV converter assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WAV_PCM_TO_FLOAT_CONVERTER_MACROS_SVH
`define WAV_PCM_TO_FLOAT_CONVERTER_MACROS_SVH
`ifndef SYNTHESIS
`define WPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WPF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WPF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/wpf_pkg.sv]
// ----------------------------------------------------------------------------
// WAV converter package
// Register indexes, widths and the float conversion functions.
// ----------------------------------------------------------------------------
package wpf_pkg;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_BITS_PER_SAMPLE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_FLOAT_FORMAT    = 1'd1;
  localparam logic [6:0] BPS_RESET = 7'd16;

  // Signed integer (two's complement, 32 bits, value already in top bits)
  // times 2^-k as float32. Leading-one search is a priority encoder.
  function automatic logic [31:0] int32_to_f32(input logic [31:0] raw,
                                               input logic [7:0] k);
    logic        sgn;
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] nrm;
    logic [24:0] q;
    logic        rnd;
    logic [7:0]  expo;
    sgn = raw[31];
    mag = sgn ? (~raw + 32'd1) : raw;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    nrm = mag << (5'd31 - p);
    // nrm[31] is the hidden bit; 8 bits below the mantissa decide rounding
    rnd = nrm[7] && ((nrm[6:0] != 7'd0) || nrm[8]);
    q = {1'b0, nrm[31:8]} + {24'd0, rnd};
    expo = 8'(p) + 8'd127 - k;
    if (raw == 32'd0) return 32'd0;
    return {sgn, 31'({expo - 8'd1, 23'd0}) + 31'(q)};
  endfunction

  // float64 to float32, round to nearest even.
  function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
    logic        sgn;
    logic [10:0] e;
    logic [51:0] f;
    logic [52:0] sig;
    logic [11:0] fexp;
    logic [5:0]  sh;
    logic [53:0] qq;
    logic [63:0] lost, half;
    logic        half_hit, above, odd;
    logic [30:0] bits;
    logic [31:0] tmp;
    logic [35:0] wide;
    sgn = d[63];
    e = d[62:52];
    f = d[51:0];
    sig = (e != 11'd0) ? {1'b1, f} : {1'b0, f};
    fexp = ((e != 11'd0) ? {1'b0, e} : 12'd1) - 12'd896;
    bits = 31'd0;
    if (e == 11'h7FF) begin
      tmp = (f == 52'd0) ? {sgn, 31'h7F800000}
                         : {sgn, 31'h7FC00000 | 31'(f[51:29])};
      return tmp;
    end
    if (!fexp[11] && fexp != 12'd0) begin
      // normal range: shift by 29, wide enough to see overflow
      odd = sig[29];
      half_hit = sig[28];
      above = sig[27:0] != 28'd0;
      qq = {30'd0, sig[52:29]} + {53'd0, half_hit && (above || odd)};
      wide = (({24'd0, fexp} - 36'd1) << 23) + 36'(qq);
      if (wide >= 36'h7F800000) bits = 31'h7F800000;
      else bits = wide[30:0];
    end else begin
      // sh = 30 - fexp, fexp <= 0
      if ((12'd0 - fexp) <= 12'd30) begin
        sh = 6'd30 + 6'(12'd0 - fexp);
        qq = {1'b0, sig} >> sh;
        lost = {11'd0, sig} & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 6'd1);
        half_hit = lost == half;
        above = lost > half;
        bits = 31'(qq) + 31'(above || (half_hit && qq[0]));
      end
    end
    return {sgn, bits};
  endfunction

endpackage

[sv/wav_pcm_to_float_converter.sv]
// out_tvalid rises in the cycle after the last byte of a sample is accepted.
// Throughput: one byte per cycle while the single result register is empty or
// being read; input stalls while a result waits and out_tready is low.
// Conversion is one level of logic between the byte register state and
// the result register. Synchronous active-low reset: registers 16-bit PCM.
// ----------------------------------------------------------------------------
// WAV PCM to float32 converter
// Assembles little-endian sample bytes and converts each sample to float32.
// ----------------------------------------------------------------------------
`include "wav_pcm_to_float_converter_macros.svh"
module wav_pcm_to_float_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sample_float
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wpf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [6:0]  cfg_data
);
  import wpf_pkg::*;

  logic [6:0]  bps_r;
  logic        flt_r;
  logic [63:0] asm_r, asm_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;
  logic [3:0]  need;
  logic        in_acc, done;
  logic [63:0] merged, word;
  logic [31:0] res;

  assign cfg_ready = 1'b1;
  assign in_tready = !ov_r || out_tready;
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  // sample length in bytes, zero for unsupported modes
  always_comb begin
    unique case (bps_r)
      7'd16: need = 4'd2;
      7'd24: need = 4'd3;
      7'd32: need = 4'd4;
      7'd64: need = flt_r ? 4'd8 : 4'd0;
      default: need = 4'd0;
    endcase
  end

  // byte assembly and conversion
  always_comb begin
    logic [63:0] base;
    logic [2:0]  p;
    base = in_tuser ? 64'd0 : asm_r;
    p = in_tuser ? 3'd0 : pos_r;
    merged = base | ({56'd0, in_tdata} << {p, 3'd0});
    done = ({1'b0, p} + 4'd1) >= need;
    word = merged;
    res = 32'd0;
    asm_nxt = asm_r;
    pos_nxt = pos_r;
    unique case (need)
      4'd2: res = int32_to_f32({merged[15:0], 16'd0}, 8'd31);
      4'd3: res = int32_to_f32({merged[23:0], 8'd0}, 8'd31);
      4'd4: res = flt_r ? merged[31:0] : int32_to_f32(merged[31:0], 8'd31);
      default: res = f64_to_f32(word);
    endcase
    if (in_acc) begin
      if (need == 4'd0 || done) begin
        asm_nxt = 64'd0;
        pos_nxt = 3'd0;
      end else begin
        asm_nxt = merged;
        pos_nxt = p + 3'd1;
      end
    end
  end

  // result register
  always_comb begin
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r;
    if (in_acc && need != 4'd0 && done) begin
      ov_nxt = 1'b1;
      od_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r <= BPS_RESET;
      flt_r <= 1'b0;
      asm_r <= 64'd0;
      pos_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      asm_r <= asm_nxt;
      pos_r <= pos_nxt;
      ov_r  <= ov_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BITS_PER_SAMPLE: bps_r <= cfg_data;
          REG_FLOAT_FORMAT:    flt_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  `WPF_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `WPF_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, {1'b0, pos_r} < 4'd8)
  `WPF_ASSERT_NXT(a_unsup_clear, clk, rst_n, in_acc && need == 4'd0, pos_r == 3'd0)
  `WPF_ASSERT_IMP(a_ready, clk, rst_n, !out_tvalid, in_tready)

endmodule
